// File: hw/rtl/edfs_pkg.sv
package edfs_pkg;

	// Fixed field widths
	localparam int TIME_BITS     = 16;
	localparam int DL_W          = TIME_BITS + 1;
	localparam int IDX_W         = 2;
	localparam int OWNER_W       = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int NUM_TASK_REGS = 3;
	localparam int MAX_TASKS_DEF = 3;
	localparam int FIFO_DEPTH    = 4;

	// Owner codes: tasks are one-based
	localparam logic [OWNER_W-1:0] OWNER_NONE = 3'd0;
	localparam logic [OWNER_W-1:0] OWNER_IDLE = 3'd4;

	// Configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TASK_COUNT   = 3'd0,
		REG_HYPER_PERIOD = 3'd1,
		REG_T0_PERIOD    = 3'd2,
		REG_T0_BUDGET    = 3'd3,
		REG_T1_PERIOD    = 3'd4,
		REG_T1_BUDGET    = 3'd5,
		REG_T2_PERIOD    = 3'd6,
		REG_T2_BUDGET    = 3'd7
	} cfg_reg_t;

	// Register reset values
	localparam logic [IDX_W-1:0]      RST_TASK_COUNT = 2'd2;
	localparam logic [TIME_BITS-1:0]  RST_HYPER      = 16'd150;
	localparam logic [TIME_BITS-1:0]  RST_PERIOD [NUM_TASK_REGS] = '{16'd50, 16'd75, 16'd100};
	localparam logic [TIME_BITS-1:0]  RST_BUDGET [NUM_TASK_REGS] = '{16'd25, 16'd30, 16'd0};

	// Best candidate passed along the cell chain
	typedef struct packed {
		logic             valid;
		logic [DL_W-1:0]  dl;
		logic [IDX_W-1:0] idx;
	} cand_t;

	// One closed segment
	typedef struct packed {
		logic [TIME_BITS-1:0] start;
		logic [TIME_BITS-1:0] stop;
		logic                 idle;
		logic [IDX_W-1:0]     task_num;
		logic                 fin;
		logic                 last;
	} seg_t;

endpackage

// File: hw/rtl/edfs_cell.sv
module edfs_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic                                 clear,
	input  logic                                 in_use,
	input  logic [edfs_pkg::TIME_BITS-1:0]       now,
	input  logic [edfs_pkg::TIME_BITS-1:0]       period,
	input  logic [edfs_pkg::TIME_BITS-1:0]       budget,
	input  edfs_pkg::cand_t                      cand_in,
	output edfs_pkg::cand_t                      cand_out,
	input  edfs_pkg::cand_t                      winner,
	output logic                                 chosen
);
	import edfs_pkg::*;

	logic [TIME_BITS-1:0] countdown_q;
	logic [TIME_BITS-1:0] budget_q;
	logic [DL_W-1:0]      deadline_q;

	logic [TIME_BITS-1:0] per_eff;
	logic                 release_now;
	logic [TIME_BITS-1:0] budget_r;
	logic [DL_W-1:0]      deadline_r;
	logic                 eligible;
	logic                 take;

	// Release: reload budget and deadline when the countdown expires
	always_comb begin
		per_eff     = (period == '0) ? TIME_BITS'(1) : period;
		release_now = (countdown_q == '0);
		budget_r    = release_now ? budget : budget_q;
		deadline_r  = release_now ? ({1'b0, now} + {1'b0, per_eff}) : deadline_q;
	end

	// Earliest deadline so far; strict compare keeps the lower index on ties
	always_comb begin
		eligible = in_use && (budget_r != '0);
		take     = eligible && (!cand_in.valid || (deadline_r < cand_in.dl));
		cand_out = cand_in;
		if (take) begin
			cand_out.valid = 1'b1;
			cand_out.dl    = deadline_r;
			cand_out.idx   = IDX_W'(CELL_IDX);
		end
	end

	assign chosen = winner.valid && (winner.idx == IDX_W'(CELL_IDX));

	// Task state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			countdown_q <= '0;
			budget_q    <= '0;
			deadline_q  <= '0;
		end else if (clear) begin
			countdown_q <= '0;
			budget_q    <= '0;
			deadline_q  <= '0;
		end else if (advance && in_use) begin
			countdown_q <= release_now ? (per_eff - TIME_BITS'(1)) : (countdown_q - TIME_BITS'(1));
			deadline_q  <= deadline_r;
			budget_q    <= chosen ? (budget_r - TIME_BITS'(1)) : budget_r;
		end
	end

endmodule

// File: hw/rtl/edfs_seg_fifo.sv
module edfs_seg_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_a,
	input  edfs_pkg::seg_t  seg_a,
	input  logic            push_b,
	input  edfs_pkg::seg_t  seg_b,
	input  logic            pop,
	output logic            head_valid,
	output edfs_pkg::seg_t  head,
	output logic            no_room
);
	import edfs_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = PTR_W + 1;

	seg_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic [PTR_W-1:0] wr_b;
	logic [CNT_W-1:0] n_push;
	logic             do_pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	// Keep room for the two segments one tick can close
	assign no_room    = (count_q > CNT_W'(FIFO_DEPTH - 2));
	assign do_pop     = pop && head_valid;
	assign wr_b       = push_a ? (wr_ptr_q + PTR_W'(1)) : wr_ptr_q;
	assign n_push     = CNT_W'(push_a) + CNT_W'(push_b);

	// Storage
	always_ff @(posedge clk) begin
		if (push_a)
			mem_q[wr_ptr_q] <= seg_a;
		if (push_b)
			mem_q[wr_b] <= seg_b;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + n_push - CNT_W'(do_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("segment fifo overflow");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !pop |=> head_valid && $stable(rd_ptr_q))
		else $error("segment fifo lost head while stalled");

	a_push_b_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_a && push_b |-> !seg_a.last && seg_b.last)
		else $error("segment order within a tick broken");

endmodule

// File: hw/rtl/edf_periodic_task_scheduler_core.sv
// EDF periodic task scheduler.
// Input channel (in_valid/in_stall, restart): each transfer with restart=0 is
// one time tick; restart=1 clears time and all task state and gives no output.
// Each tick releases tasks whose countdown expired, runs the ready task with
// the earliest deadline (lowest index on ties) and closes the current segment
// when the owner changes. The tick that ends the hyper-period also closes the
// final segment, so a tick yields zero, one or two segment transfers; the
// last one carries last=1. After that, ticks are ignored until restart.
// Output channel (out_valid/out_stall): segments in order, from a 4-entry
// fifo that registers each segment as its tick is taken. One tick is taken
// per cycle while in_stall is low; selection runs through a chain of one cell
// per task in that cycle. in_stall is high once three or four segments are
// queued (under two free entries), so an output stall backs up into the input.
// Config port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready. The
// user must write it only while the block is idle; the block does not check.
// Reset: registers take their defaults (2 tasks, hyper-period 150, periods
// 50/75/100, budgets 25/30/0), time and task state clear, fifo empties.
module edf_periodic_task_scheduler_core #(
	parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [edfs_pkg::TIME_BITS-1:0]      seg_start,
	output logic [edfs_pkg::TIME_BITS-1:0]      seg_end,
	output logic                                seg_idle,
	output logic [edfs_pkg::IDX_W-1:0]          task_number,
	output logic                                final_segment,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [edfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [edfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import edfs_pkg::*;

	// Configuration registers
	logic [IDX_W-1:0]     task_count_q;
	logic [TIME_BITS-1:0] hyper_q;
	logic [TIME_BITS-1:0] period_q [NUM_TASK_REGS];
	logic [TIME_BITS-1:0] budget_q [NUM_TASK_REGS];

	// Run state
	logic [TIME_BITS-1:0] tick_q;
	logic [TIME_BITS-1:0] seg_begin_q;
	logic [OWNER_W-1:0]   owner_q;

	logic                 tick_take;
	logic                 run_active;
	logic                 advance;
	logic                 clear;
	logic [IDX_W-1:0]     count_eff;
	cand_t                chain [MAX_TASKS+1];
	logic [MAX_TASKS-1:0] chosen_vec;
	logic [OWNER_W-1:0]   owner_new;
	logic                 owner_chg;
	logic [TIME_BITS-1:0] tick_nxt;
	logic                 fin;
	logic                 emit_chg;
	logic [TIME_BITS-1:0] begin_eff;
	logic [OWNER_W-1:0]   owner_eff;
	seg_t                 seg_chg;
	seg_t                 seg_fin;
	seg_t                 head;
	logic                 no_room;

	assign cfg_ready = 1'b1;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= RST_TASK_COUNT;
			hyper_q      <= RST_HYPER;
			period_q     <= RST_PERIOD;
			budget_q     <= RST_BUDGET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TASK_COUNT:   task_count_q <= cfg_data[IDX_W-1:0];
				REG_HYPER_PERIOD: hyper_q      <= cfg_data[TIME_BITS-1:0];
				REG_T0_PERIOD:    period_q[0]  <= cfg_data[TIME_BITS-1:0];
				REG_T0_BUDGET:    budget_q[0]  <= cfg_data[TIME_BITS-1:0];
				REG_T1_PERIOD:    period_q[1]  <= cfg_data[TIME_BITS-1:0];
				REG_T1_BUDGET:    budget_q[1]  <= cfg_data[TIME_BITS-1:0];
				REG_T2_PERIOD:    period_q[2]  <= cfg_data[TIME_BITS-1:0];
				REG_T2_BUDGET:    budget_q[2]  <= cfg_data[TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Tick control
	assign in_stall   = no_room;
	assign tick_take  = in_valid && !in_stall;
	assign run_active = (tick_q < hyper_q);
	assign advance    = tick_take && !restart && run_active;
	assign clear      = tick_take && restart;
	assign count_eff  = (task_count_q > IDX_W'(MAX_TASKS)) ? IDX_W'(MAX_TASKS) : task_count_q;

	// Chain of task cells, one per task
	assign chain[0] = '0;
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		edfs_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.clear    (clear),
			.in_use   (IDX_W'(i) < count_eff),
			.now      (tick_q),
			.period   (period_q[i]),
			.budget   (budget_q[i]),
			.cand_in  (chain[i]),
			.cand_out (chain[i+1]),
			.winner   (chain[MAX_TASKS]),
			.chosen   (chosen_vec[i])
		);
	end

	// Owner change and segment build
	always_comb begin
		owner_new = chain[MAX_TASKS].valid ?
			(OWNER_W'(chain[MAX_TASKS].idx) + OWNER_W'(1)) : OWNER_IDLE;
		owner_chg = (owner_new != owner_q);
		emit_chg  = advance && owner_chg && (owner_q != OWNER_NONE);
		tick_nxt  = tick_q + TIME_BITS'(1);
		fin       = advance && ((tick_nxt == hyper_q) || (tick_nxt == '0));
		begin_eff = owner_chg ? tick_q : seg_begin_q;
		owner_eff = owner_chg ? owner_new : owner_q;

		seg_chg.start    = seg_begin_q;
		seg_chg.stop     = tick_q;
		seg_chg.idle     = (owner_q == OWNER_IDLE);
		seg_chg.task_num = (owner_q == OWNER_IDLE) ? '0 : owner_q[IDX_W-1:0];
		seg_chg.fin      = 1'b0;
		seg_chg.last     = !fin;

		seg_fin.start    = begin_eff;
		seg_fin.stop     = tick_nxt;
		seg_fin.idle     = (owner_eff == OWNER_IDLE);
		seg_fin.task_num = (owner_eff == OWNER_IDLE) ? '0 : owner_eff[IDX_W-1:0];
		seg_fin.fin      = 1'b1;
		seg_fin.last     = 1'b1;
	end

	// Time, segment start and owner
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			seg_begin_q <= '0;
			owner_q     <= OWNER_NONE;
		end else if (clear) begin
			tick_q      <= '0;
			seg_begin_q <= '0;
			owner_q     <= OWNER_NONE;
		end else if (advance) begin
			tick_q <= fin ? hyper_q : tick_nxt;
			if (owner_chg) begin
				seg_begin_q <= tick_q;
				owner_q     <= owner_new;
			end
		end
	end

	// Output queue
	edfs_seg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_a     (emit_chg),
		.seg_a      (seg_chg),
		.push_b     (fin),
		.seg_b      (seg_fin),
		.pop        (!out_stall),
		.head_valid (out_valid),
		.head       (head),
		.no_room    (no_room)
	);

	assign seg_start     = head.start;
	assign seg_end       = head.stop;
	assign seg_idle      = head.idle;
	assign task_number   = head.task_num;
	assign final_segment = head.fin;
	assign last          = head.last;

	a_one_winner: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(chosen_vec))
		else $error("more than one task selected");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> !run_active)
		else $error("run still active after final segment");

	a_owner_set: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> owner_q != OWNER_NONE)
		else $error("no owner after an active tick");

endmodule
